FILE: rtl/gsti_pkg.sv
// Shared types and constants for the grid store with trilinear interpolation.
// Used by gsti_ctrl, gsti_datapath and grid_store_trilinear_interp_unit.
`timescale 1ns / 1ps

package gsti_pkg;

    localparam int DATA_W    = 32;
    localparam int CELL_W    = 4;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_WR_IDX = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_IDX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_CRD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_CRD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FILL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INTERP = 3'd5;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOB = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_W_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_W_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_W_Z  = 3'd5;

    // Index of the last of the seven lerps.
    localparam logic [2:0] LERP_LAST = 3'd6;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MEM,
        RES_LERP
    } res_sel_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic       latch;
        logic       mul_scale;
        axis_t      mul_axis;
        logic       cap_scale;
        axis_t      cap_axis;
        logic       mem_wr;
        logic       mem_rd;
        logic       fill_step;
        logic       corner_rd;
        logic [2:0] corner;
        logic       corner_cap;
        logic [2:0] cap_slot;
        logic       lerp_mul;
        logic       lerp_add;
        logic [2:0] lerp_step;
        logic       out_load;
        res_sel_t   res_sel;
        logic       out_status;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_oob;
        logic             coord_oob;
        logic             fill_last;
        logic             out_busy;
    } sts_t;

endpackage

FILE: rtl/gsti_ctrl.sv
// Controller state machine for the grid store: sequences scaling, memory
// accesses, corner loads, lerps and fills. Depends on gsti_pkg.
`timescale 1ns / 1ps

module gsti_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gsti_pkg::sts_t sts,
    output gsti_pkg::ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_IDX,
        S_MX,
        S_MY,
        S_MZ,
        S_CHK,
        S_ACC,
        S_CRD,
        S_LMUL,
        S_LADD,
        S_FILL,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          k_reg, k_next;
    logic [2:0]          step_reg, step_next;
    gsti_pkg::res_sel_t  res_sel_reg, res_sel_next;
    logic                stat_reg, stat_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        step_next    = step_reg;
        res_sel_next = res_sel_reg;
        stat_next    = stat_reg;
        ctl            = '0;
        ctl.mul_axis   = gsti_pkg::AXIS_X;
        ctl.cap_axis   = gsti_pkg::AXIS_X;
        ctl.res_sel    = res_sel_reg;
        ctl.out_status = stat_reg;
        ctl.corner     = k_reg[2:0];
        ctl.cap_slot   = 3'(k_reg - 4'd1);
        ctl.lerp_step  = step_reg;

        case (state_reg)
            S_IDLE:
            begin
                ctl.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.cmd) inside
                    gsti_pkg::CMD_WR_IDX, gsti_pkg::CMD_RD_IDX:
                    begin
                        state_next = S_IDX;
                    end
                    gsti_pkg::CMD_WR_CRD, gsti_pkg::CMD_RD_CRD, gsti_pkg::CMD_INTERP:
                    begin
                        state_next = S_MX;
                    end
                    gsti_pkg::CMD_FILL:
                    begin
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        res_sel_next = gsti_pkg::RES_ZERO;
                        stat_next    = gsti_pkg::STATUS_OOB;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_IDX:
            begin
                state_next = S_DONE;
                if (sts.idx_oob)
                begin
                    res_sel_next = gsti_pkg::RES_ZERO;
                    stat_next    = gsti_pkg::STATUS_OOB;
                end
                else if (sts.cmd == gsti_pkg::CMD_WR_IDX)
                begin
                    ctl.mem_wr   = 1'b1;
                    res_sel_next = gsti_pkg::RES_ZERO;
                    stat_next    = gsti_pkg::STATUS_OK;
                end
                else
                begin
                    ctl.mem_rd   = 1'b1;
                    res_sel_next = gsti_pkg::RES_MEM;
                    stat_next    = gsti_pkg::STATUS_OK;
                end
            end
            S_MX:
            begin
                ctl.mul_scale = 1'b1;
                ctl.mul_axis  = gsti_pkg::AXIS_X;
                state_next    = S_MY;
            end
            S_MY:
            begin
                ctl.cap_scale = 1'b1;
                ctl.cap_axis  = gsti_pkg::AXIS_X;
                ctl.mul_scale = 1'b1;
                ctl.mul_axis  = gsti_pkg::AXIS_Y;
                state_next    = S_MZ;
            end
            S_MZ:
            begin
                ctl.cap_scale = 1'b1;
                ctl.cap_axis  = gsti_pkg::AXIS_Y;
                ctl.mul_scale = 1'b1;
                ctl.mul_axis  = gsti_pkg::AXIS_Z;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                ctl.cap_scale = 1'b1;
                ctl.cap_axis  = gsti_pkg::AXIS_Z;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                stat_next    = gsti_pkg::STATUS_OK;
                res_sel_next = gsti_pkg::RES_ZERO;
                state_next   = S_DONE;
                if (sts.coord_oob)
                begin
                    stat_next = gsti_pkg::STATUS_OOB;
                end
                else if (sts.cmd == gsti_pkg::CMD_WR_CRD)
                begin
                    ctl.mem_wr = 1'b1;
                end
                else if (sts.cmd == gsti_pkg::CMD_RD_CRD)
                begin
                    ctl.mem_rd   = 1'b1;
                    res_sel_next = gsti_pkg::RES_MEM;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                // Read data is registered, so slot k-1 is loaded
                // while corner k is addressed.
                ctl.corner_rd  = !k_reg[3];
                ctl.corner_cap = (k_reg != '0);
                if (k_reg[3])
                begin
                    step_next  = '0;
                    state_next = S_LMUL;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
            S_LMUL:
            begin
                ctl.lerp_mul = 1'b1;
                state_next   = S_LADD;
            end
            S_LADD:
            begin
                ctl.lerp_add = 1'b1;
                if (step_reg == gsti_pkg::LERP_LAST)
                begin
                    res_sel_next = gsti_pkg::RES_LERP;
                    stat_next    = gsti_pkg::STATUS_OK;
                    state_next   = S_DONE;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_LMUL;
                end
            end
            S_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    res_sel_next = gsti_pkg::RES_ZERO;
                    stat_next    = gsti_pkg::STATUS_OK;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            step_reg    <= '0;
            res_sel_reg <= gsti_pkg::RES_ZERO;
            stat_reg    <= gsti_pkg::STATUS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            step_reg    <= step_next;
            res_sel_reg <= res_sel_next;
            stat_reg    <= stat_next;
        end
    end

endmodule

FILE: rtl/gsti_datapath.sv
// Datapath of the grid store: configuration registers, cell memory, shared
// multiplier, scaled coordinates, corner queue and output register.
// Depends on gsti_pkg; driven by gsti_ctrl.
`timescale 1ns / 1ps

module gsti_datapath #(
    parameter int RES_X     = 16,
    parameter int RES_Y     = 16,
    parameter int RES_Z     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gsti_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [gsti_pkg::DATA_W-1:0]         cfg_data,
    input  logic [gsti_pkg::CMD_W-1:0]          cmd,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_x,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_y,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_z,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_x,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_y,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_z,
    input  logic signed [gsti_pkg::DATA_W-1:0]  wr_value,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [gsti_pkg::DATA_W-1:0]  result_value,
    output logic                                status,
    input  gsti_pkg::ctl_t                      ctl,
    output gsti_pkg::sts_t                      sts
);

    localparam int NCELLS = RES_X * RES_Y * RES_Z;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(RES_X);
    localparam int YW     = $clog2(RES_Y);
    localparam int ZW     = $clog2(RES_Z);
    localparam int SXW    = FRAC_BITS + XW;
    localparam int SYW    = FRAC_BITS + YW;
    localparam int SZW    = FRAC_BITS + ZW;
    localparam int TW     = FRAC_BITS + 1;
    localparam logic [63:0] LIM_X = 64'(RES_X - 1) << FRAC_BITS;
    localparam logic [63:0] LIM_Y = 64'(RES_Y - 1) << FRAC_BITS;
    localparam logic [63:0] LIM_Z = 64'(RES_Z - 1) << FRAC_BITS;

    // Configuration registers.
    logic [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg;

    // Latched transaction.
    logic [gsti_pkg::CMD_W-1:0]  cmd_reg;
    logic [gsti_pkg::CELL_W-1:0] cell_x_reg, cell_y_reg, cell_z_reg;
    logic [31:0]                 coord_x_reg, coord_y_reg, coord_z_reg;
    logic [31:0]                 wr_value_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_reg;
    logic               neg_reg;

    logic [SXW-1:0] s_x_reg;
    logic [SYW-1:0] s_y_reg;
    logic [SZW-1:0] s_z_reg;
    logic           ok_x_reg, ok_y_reg, ok_z_reg;

    logic signed [31:0] q_reg [8];

    logic [AW-1:0] fill_cnt_reg;
    logic [31:0]   mem [NCELLS];
    logic [31:0]   rd_data_reg;

    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic        status_reg;

    function automatic logic [AW-1:0] flat_addr(input logic [AW-1:0] x,
                                                input logic [AW-1:0] y,
                                                input logic [AW-1:0] z);
        return AW'((x * AW'(RES_Y) + y) * AW'(RES_Z) + z);
    endfunction

    // Coordinate difference for the axis being scaled.
    logic [31:0]        crd_sel, org_sel, inv_sel;
    logic signed [32:0] diff_s;

    always_comb
    begin
        case (ctl.mul_axis)
            gsti_pkg::AXIS_Y:
            begin
                crd_sel = coord_y_reg;
                org_sel = origin_y_reg;
                inv_sel = inv_y_reg;
            end
            gsti_pkg::AXIS_Z:
            begin
                crd_sel = coord_z_reg;
                org_sel = origin_z_reg;
                inv_sel = inv_z_reg;
            end
            default:
            begin
                crd_sel = coord_x_reg;
                org_sel = origin_x_reg;
                inv_sel = inv_x_reg;
            end
        endcase
        diff_s = $signed({crd_sel[31], crd_sel}) - $signed({org_sel[31], org_sel});
    end

    // Scaled coordinate split into lower index (clamped for interpolation) and weight.
    logic [XW-1:0] ix, ix_cl;
    logic [YW-1:0] iy, iy_cl;
    logic [ZW-1:0] iz, iz_cl;
    logic [TW-1:0] t_x, t_y, t_z, t_sel;

    always_comb
    begin
        ix    = s_x_reg[SXW-1:FRAC_BITS];
        iy    = s_y_reg[SYW-1:FRAC_BITS];
        iz    = s_z_reg[SZW-1:FRAC_BITS];
        ix_cl = (ix > XW'(RES_X - 2)) ? XW'(RES_X - 2) : ix;
        iy_cl = (iy > YW'(RES_Y - 2)) ? YW'(RES_Y - 2) : iy;
        iz_cl = (iz > ZW'(RES_Z - 2)) ? ZW'(RES_Z - 2) : iz;
        t_x   = TW'(s_x_reg - {ix_cl, {FRAC_BITS{1'b0}}});
        t_y   = TW'(s_y_reg - {iy_cl, {FRAC_BITS{1'b0}}});
        t_z   = TW'(s_z_reg - {iz_cl, {FRAC_BITS{1'b0}}});
        if (ctl.lerp_step < 3'd4)
        begin
            t_sel = t_z;
        end
        else if (ctl.lerp_step < 3'd6)
        begin
            t_sel = t_y;
        end
        else
        begin
            t_sel = t_x;
        end
    end

    // One multiplier serves both the coordinate scaling and the lerps.
    logic signed [32:0] lerp_diff;

    always_comb
    begin
        lerp_diff = $signed({q_reg[1][31], q_reg[1]}) - $signed({q_reg[0][31], q_reg[0]});
        if (ctl.lerp_mul)
        begin
            mul_a = $signed({lerp_diff[32], lerp_diff});
            mul_b = $signed({{(34 - TW){1'b0}}, t_sel});
        end
        else
        begin
            mul_a = $signed({2'b00, diff_s[31:0]});
            mul_b = $signed({2'b00, inv_sel});
        end
    end

    logic [63:0]        sc;
    logic signed [67:0] lerp_rnd, lerp_shr;
    logic [31:0]        lerp_res;

    always_comb
    begin
        sc       = mul_reg[63:0] >> FRAC_BITS;
        lerp_rnd = mul_reg + (68'sd1 <<< (FRAC_BITS - 1));
        lerp_shr = lerp_rnd >>> FRAC_BITS;
        lerp_res = q_reg[0] + lerp_shr[31:0];
    end

    // Memory addresses.
    logic [AW-1:0] tgt_addr, corner_addr, wr_addr, rd_addr;
    logic          is_idx_cmd;
    logic          mem_we, mem_re;

    always_comb
    begin
        is_idx_cmd = (cmd_reg == gsti_pkg::CMD_WR_IDX) || (cmd_reg == gsti_pkg::CMD_RD_IDX);
        if (is_idx_cmd)
        begin
            tgt_addr = flat_addr(AW'(cell_x_reg), AW'(cell_y_reg), AW'(cell_z_reg));
        end
        else
        begin
            tgt_addr = flat_addr(AW'(ix), AW'(iy), AW'(iz));
        end
        corner_addr = flat_addr(AW'(ix_cl) + AW'(ctl.corner[2]),
                                AW'(iy_cl) + AW'(ctl.corner[1]),
                                AW'(iz_cl) + AW'(ctl.corner[0]));
        mem_we  = ctl.mem_wr || ctl.fill_step;
        wr_addr = ctl.fill_step ? fill_cnt_reg : tgt_addr;
        mem_re  = ctl.mem_rd || ctl.corner_rd;
        rd_addr = ctl.corner_rd ? corner_addr : tgt_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_value_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_x_reg    <= 32'd65536;
            inv_y_reg    <= 32'd65536;
            inv_z_reg    <= 32'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                gsti_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                gsti_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                gsti_pkg::CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                gsti_pkg::CFG_INV_W_X:  inv_x_reg    <= cfg_data;
                gsti_pkg::CFG_INV_W_Y:  inv_y_reg    <= cfg_data;
                gsti_pkg::CFG_INV_W_Z:  inv_z_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg      <= cmd;
            cell_x_reg   <= cell_x;
            cell_y_reg   <= cell_y;
            cell_z_reg   <= cell_z;
            coord_x_reg  <= coord_x;
            coord_y_reg  <= coord_y;
            coord_z_reg  <= coord_z;
            wr_value_reg <= wr_value;
        end
        if (ctl.mul_scale || ctl.lerp_mul)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (ctl.mul_scale)
        begin
            neg_reg <= diff_s[32];
        end
        if (ctl.cap_scale)
        begin
            case (ctl.cap_axis)
                gsti_pkg::AXIS_Y:
                begin
                    s_y_reg  <= sc[SYW-1:0];
                    ok_y_reg <= !neg_reg && (sc <= LIM_Y);
                end
                gsti_pkg::AXIS_Z:
                begin
                    s_z_reg  <= sc[SZW-1:0];
                    ok_z_reg <= !neg_reg && (sc <= LIM_Z);
                end
                default:
                begin
                    s_x_reg  <= sc[SXW-1:0];
                    ok_x_reg <= !neg_reg && (sc <= LIM_X);
                end
            endcase
        end
        if (ctl.corner_cap)
        begin
            q_reg[ctl.cap_slot] <= rd_data_reg;
        end
        // Each lerp consumes the two front entries and appends its result, so
        // the z, y and x pairs line up at the front in turn.
        if (ctl.lerp_add)
        begin
            for (int i = 0; i < 6; i++)
            begin
                q_reg[i] <= q_reg[i + 2];
            end
            q_reg[3'(gsti_pkg::LERP_LAST - ctl.lerp_step)] <= lerp_res;
        end
        if (ctl.out_load)
        begin
            status_reg <= ctl.out_status;
            case (ctl.res_sel)
                gsti_pkg::RES_MEM:  result_reg <= rd_data_reg;
                gsti_pkg::RES_LERP: result_reg <= q_reg[0];
                default:            result_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.latch)
            begin
                fill_cnt_reg <= '0;
            end
            else if (ctl.fill_step)
            begin
                fill_cnt_reg <= fill_cnt_reg + AW'(1);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.idx_oob   = (9'(cell_x_reg) >= 9'(RES_X)) || (9'(cell_y_reg) >= 9'(RES_Y)) ||
                        (9'(cell_z_reg) >= 9'(RES_Z));
        sts.coord_oob = !(ok_x_reg && ok_y_reg && ok_z_reg);
        sts.fill_last = (fill_cnt_reg == AW'(NCELLS - 1));
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

FILE: rtl/grid_store_trilinear_interp_unit.sv
// One transaction is in work at a time. Every coordinate command uses the shared
// multiplier for three scalings; interpolation also makes eight corner reads through
// the single memory read port and seven lerps on the same multiplier, in turn.
// A finished result waits in the output register while the next one is accepted.
// Reset initialises control and configuration; cell contents are undefined until written.
`timescale 1ns / 1ps

module grid_store_trilinear_interp_unit #(
    parameter int RES_X     = 16,
    parameter int RES_Y     = 16,
    parameter int RES_Z     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gsti_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [gsti_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gsti_pkg::CMD_W-1:0]          cmd,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_x,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_y,
    input  logic [gsti_pkg::CELL_W-1:0]         cell_z,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_x,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_y,
    input  logic signed [gsti_pkg::DATA_W-1:0]  coord_z,
    input  logic signed [gsti_pkg::DATA_W-1:0]  wr_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gsti_pkg::DATA_W-1:0]  result_value,
    output logic                                status
);

    gsti_pkg::ctl_t ctl;
    gsti_pkg::sts_t sts;

    gsti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    gsti_datapath #(
        .RES_X     (RES_X),
        .RES_Y     (RES_Y),
        .RES_Z     (RES_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .wr_value     (wr_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_value (result_value),
        .status       (status),
        .ctl          (ctl),
        .sts          (sts)
    );

    // An accepted transaction closes the input side.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // The single write port is never claimed by a cell write and a fill at once.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.mem_wr && ctl.fill_step))
        else $error("cell write and fill collide");

    // Every lerp update uses a product launched in the previous cycle.
    a_lerp_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.lerp_add |-> $past(ctl.lerp_mul))
        else $error("lerp update without product");

    // A result is loaded only when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

endmodule

FILE: tb/tb_grid_store_trilinear_interp_unit.sv
// Self-checking testbench for grid_store_trilinear_interp_unit.
// It predicts each result from its own copy of the cell store and configuration.
// Depends on rtl/gsti_pkg.sv and the unit RTL.
`timescale 1ns / 1ps

module tb_grid_store_trilinear_interp_unit;

    localparam int  RES       = 16;
    localparam int  NCELLS    = RES * RES * RES;
    localparam int  FRAC      = 16;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [2:0] CMD_BAD_6 = 3'd6;
    localparam logic [2:0] CMD_BAD_7 = 3'd7;

    typedef struct {
        logic [31:0] value;
        logic        stat;
    } grid_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [gsti_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [gsti_pkg::CMD_W-1:0]  cmd = '0;
    logic [gsti_pkg::CELL_W-1:0] cell_x = '0, cell_y = '0, cell_z = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0, wr_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic        status;

    logic [31:0]  grid_cells [NCELLS];
    logic [31:0]  org_q [3];
    logic [31:0]  inv_q [3];
    grid_answer_t answers_due [$];
    int           error_count = 0;
    longint       cycle_count = 0;
    int           burst_left = 0;

    grid_store_trilinear_interp_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- Predictor ----------------

    function automatic bit scale_axis(input logic [31:0] c, input logic [31:0] org,
                                      input logic [31:0] inv, output logic [63:0] s);
        longint d;
        logic [63:0] prod;
        d = longint'($signed(c)) - longint'($signed(org));
        s = '0;
        if (d < 0)
            return 1'b0;
        prod = 64'(d) * 64'(inv);
        s = prod >> FRAC;
        return s <= (64'(RES - 1) << FRAC);
    endfunction

    function automatic longint lerp_q(input longint a, input longint b, input longint t);
        longint p;
        p = (b - a) * t;
        return a + ((p + (longint'(1) << (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic longint cell_at(input int x, input int y, input int z);
        return longint'($signed(grid_cells[(x * RES + y) * RES + z]));
    endfunction

    task automatic grid_execute(input logic [2:0] op, input int cx, input int cy,
                                input int cz, input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz, input logic [31:0] wv,
                                output grid_answer_t ans);
        logic [63:0] sx, sy, sz;
        int ix, iy, iz;
        longint tx, ty, tz, c00, c01, c10, c11, c0, c1;
        bit ok;
        ans.value = '0;
        ans.stat = gsti_pkg::STATUS_OK;
        case (op)
            gsti_pkg::CMD_WR_IDX: grid_cells[(cx * RES + cy) * RES + cz] = wv;
            gsti_pkg::CMD_RD_IDX: ans.value = grid_cells[(cx * RES + cy) * RES + cz];
            gsti_pkg::CMD_FILL:   foreach (grid_cells[i]) grid_cells[i] = wv;
            gsti_pkg::CMD_WR_CRD, gsti_pkg::CMD_RD_CRD, gsti_pkg::CMD_INTERP:
            begin
                ok = scale_axis(px, org_q[0], inv_q[0], sx);
                ok = ok && scale_axis(py, org_q[1], inv_q[1], sy);
                ok = ok && scale_axis(pz, org_q[2], inv_q[2], sz);
                if (!ok)
                    ans.stat = gsti_pkg::STATUS_OOB;
                else
                begin
                    ix = int'(sx >> FRAC);
                    iy = int'(sy >> FRAC);
                    iz = int'(sz >> FRAC);
                    if (op == gsti_pkg::CMD_WR_CRD)
                        grid_cells[(ix * RES + iy) * RES + iz] = wv;
                    else if (op == gsti_pkg::CMD_RD_CRD)
                        ans.value = grid_cells[(ix * RES + iy) * RES + iz];
                    else
                    begin
                        // The lower corner stays one below the top so the weight reaches 1.0.
                        if (ix > RES - 2) ix = RES - 2;
                        if (iy > RES - 2) iy = RES - 2;
                        if (iz > RES - 2) iz = RES - 2;
                        tx = longint'(sx) - (longint'(ix) << FRAC);
                        ty = longint'(sy) - (longint'(iy) << FRAC);
                        tz = longint'(sz) - (longint'(iz) << FRAC);
                        c00 = lerp_q(cell_at(ix, iy, iz), cell_at(ix, iy, iz + 1), tz);
                        c01 = lerp_q(cell_at(ix, iy + 1, iz), cell_at(ix, iy + 1, iz + 1), tz);
                        c10 = lerp_q(cell_at(ix + 1, iy, iz), cell_at(ix + 1, iy, iz + 1), tz);
                        c11 = lerp_q(cell_at(ix + 1, iy + 1, iz),
                                     cell_at(ix + 1, iy + 1, iz + 1), tz);
                        c0 = lerp_q(c00, c01, ty);
                        c1 = lerp_q(c10, c11, ty);
                        ans.value = 32'(lerp_q(c0, c1, tx));
                    end
                end
            end
            default: ans.stat = gsti_pkg::STATUS_OOB;
        endcase
    endtask

    // ---------------- Driving ----------------

    task automatic send_item(input logic [2:0] op, input int cx, input int cy, input int cz,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] wv);
        int gap;
        grid_answer_t ans;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= op;
        cell_x   <= gsti_pkg::CELL_W'(cx);
        cell_y   <= gsti_pkg::CELL_W'(cy);
        cell_z   <= gsti_pkg::CELL_W'(cz);
        coord_x  <= px;
        coord_y  <= py;
        coord_z  <= pz;
        wr_value <= wv;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        grid_execute(op, cx, cy, cz, px, py, pz, wv, ans);
        answers_due.push_back(ans);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_geometry(input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] oz, input logic [31:0] wx,
                                 input logic [31:0] wy, input logic [31:0] wz);
        logic [31:0] vals [6];
        logic [gsti_pkg::CFG_IDX_W-1:0] regs [6];
        vals = '{ox, oy, oz, wx, wy, wz};
        regs = '{gsti_pkg::CFG_ORIGIN_X, gsti_pkg::CFG_ORIGIN_Y, gsti_pkg::CFG_ORIGIN_Z,
                 gsti_pkg::CFG_INV_W_X, gsti_pkg::CFG_INV_W_Y, gsti_pkg::CFG_INV_W_Z};
        wait_idle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        org_q = '{ox, oy, oz};
        inv_q = '{wx, wy, wz};
    endtask

    // A coordinate that usually lands inside the grid on one axis.
    function automatic logic [31:0] pick_coord(input int axis);
        logic [63:0] span;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        span = (inv_q[axis] == 0) ? 64'h7FFF_FFFF : ((64'd16 << 32) / inv_q[axis]);
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        return org_q[axis] + $urandom_range(0, 32'(span)) - (($urandom_range(0, 15) == 0) ? 3 : 0);
    endfunction

    // ---------------- Receiving and checking ----------------

    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        grid_answer_t want;
        if (out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result transaction: result_value %0d status %0d",
                       result_value, status);
                error_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d", $signed(want.value),
                           result_value);
                    error_count++;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, actual %0d", want.stat, status);
                    error_count++;
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // ---------------- Tests ----------------

    task automatic test_indexed_access();
        send_item(gsti_pkg::CMD_WR_IDX, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
        send_item(gsti_pkg::CMD_RD_IDX, 0, 0, 0, 0, 0, 0, 0);
        send_item(gsti_pkg::CMD_WR_IDX, 15, 15, 15, 0, 0, 0, 32'h7FFF_FFFF);
        send_item(gsti_pkg::CMD_RD_IDX, 15, 15, 15, 0, 0, 0, 0);
        send_item(gsti_pkg::CMD_FILL, 0, 0, 0, 0, 0, 0, 32'h0001_8000);
        send_item(gsti_pkg::CMD_RD_IDX, 7, 3, 11, 0, 0, 0, 0);
    endtask

    task automatic test_coord_access();
        send_item(gsti_pkg::CMD_WR_CRD, 0, 0, 0, 32'h0003_8000, 32'h000F_0000, 0,
                  32'hFFFF_0000);
        send_item(gsti_pkg::CMD_RD_CRD, 0, 0, 0, 32'h0003_0001, 32'h000F_0000,
                  32'h0000_FFFF, 0);
        send_item(gsti_pkg::CMD_RD_IDX, 3, 15, 0, 0, 0, 0, 0);
        // Just below the origin, and just past the last cell.
        send_item(gsti_pkg::CMD_RD_CRD, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(gsti_pkg::CMD_WR_CRD, 0, 0, 0, 0, 32'h000F_0001, 0, 32'h1234);
        send_item(gsti_pkg::CMD_RD_CRD, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    endtask

    task automatic test_interpolation();
        for (int i = 0; i < 8; i++)
            send_item(gsti_pkg::CMD_WR_IDX, 4 + i[2], 5 + i[1], 6 + i[0], 0, 0, 0,
                      (i[0] ? 32'h0010_0000 : 32'hFFF0_0000) + 32'(i * 32'h3_1000));
        send_item(gsti_pkg::CMD_INTERP, 0, 0, 0, 32'h0004_4000, 32'h0005_8000,
                  32'h0006_C001, 0);
        send_item(gsti_pkg::CMD_INTERP, 0, 0, 0, 32'h0004_0000, 32'h0005_0000,
                  32'h0006_0000, 0);
        // Top of every axis: the weight is exactly one.
        send_item(gsti_pkg::CMD_INTERP, 0, 0, 0, 32'h000F_0000, 32'h000F_0000,
                  32'h000F_0000, 0);
        send_item(gsti_pkg::CMD_INTERP, 0, 0, 0, 32'h0010_0000, 0, 0, 0);
    endtask

    task automatic test_unknown_commands();
        send_item(CMD_BAD_6, 1, 2, 3, 32'h0001_0000, 0, 0, 32'hDEAD_BEEF);
        send_item(CMD_BAD_7, 15, 0, 15, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(gsti_pkg::CMD_RD_IDX, 1, 2, 3, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [2:0] op;
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 40)       op = gsti_pkg::CMD_WR_IDX;
            else if (pick < 70)  op = gsti_pkg::CMD_RD_IDX;
            else if (pick < 95)  op = gsti_pkg::CMD_WR_CRD;
            else if (pick < 120) op = gsti_pkg::CMD_RD_CRD;
            else if (pick < 121) op = gsti_pkg::CMD_FILL;
            else if (pick < 196) op = gsti_pkg::CMD_INTERP;
            else                 op = 3'($urandom_range(6, 7));
            send_item(op, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                      pick_coord(0), pick_coord(1), pick_coord(2), $urandom);
        end
    endtask

    initial
    begin
        org_q = '{32'd0, 32'd0, 32'd0};
        inv_q = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_indexed_access();
        test_coord_access();
        test_interpolation();
        test_unknown_commands();

        test_random_traffic(180);
        load_geometry(32'hFFFB_0000, 32'h0002_8000, 32'hFFFF_C000,
                      32'h0002_0000, 32'h0000_8000, 32'h0001_8000);
        test_random_traffic(180);
        load_geometry(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h0000_0010, 32'h0000_0001, 32'h0000_0100);
        test_random_traffic(160);
        load_geometry(32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h0, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h0100_0000);
        test_random_traffic(160);
        load_geometry(32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        test_random_traffic(160);
        load_geometry($urandom, $urandom, $urandom, $urandom_range(1, 32'h0004_0000),
                      $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000));
        test_random_traffic(160);
        load_geometry(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        test_random_traffic(280);

        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
